// File: hdl/rsq_pkg.sv
// Shared types and constants for the rotated sprite quad expander.
// Used by rsq_sine, rsq_vertex and rotated_sprite_quad_expand; depends on nothing.
package rsq_pkg;

    // Latency of the quarter-sine pipeline in register stages.
    localparam int SINE_LAT = 8;

    // Odd sine polynomial coefficients, Q1.30, in Horner order.
    localparam logic [30:0] SIN_C11 = 31'd3864;
    localparam logic [30:0] HORNER_C [5] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598667, 31'd1686629713
    };

    // A quarter turn in angle units.
    localparam logic [14:0] QUARTER_TURN = 15'd16384;

    // Corner codes in output order.
    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_TR = 2'd2,
        CORNER_TL = 2'd3
    } corner_t;

    // One sprite, ready for corner expansion.
    typedef struct packed {
        logic signed [34:0] base_x;   // pos_x + origin x
        logic signed [34:0] base_y;
        logic signed [33:0] x_left;   // corner offsets from the origin
        logic signed [33:0] x_right;
        logic signed [33:0] y_bot;
        logic signed [33:0] y_top;
        logic signed [29:0] sn;       // Q2.28
        logic signed [29:0] cs;
        logic [15:0]        u0;
        logic [15:0]        u1;
        logic [15:0]        v0;
        logic [15:0]        v1;
        logic [31:0]        tint;
    } sprite_t;

endpackage

// File: hdl/rsq_sine.sv
// Pipelined quarter-wave sine: sin(pi/2 * f/16384) in Q1.28 by an odd polynomial.
// Depends on rsq_pkg for the coefficients.
module rsq_sine import rsq_pkg::*; (
    input  logic        aclk,
    input  logic        ce,
    input  logic [14:0] f_in,
    output logic [28:0] sin_out
);

    logic [30:0] t_pipe_reg  [1:7];
    logic [30:0] t2_pipe_reg [2:6];
    logic [30:0] acc_reg     [3:7];
    logic [28:0] sin_reg;
    logic [61:0] tt;
    logic [61:0] fin;

    assign tt  = 62'(t_pipe_reg[1]) * 62'(t_pipe_reg[1]);
    assign fin = 62'(acc_reg[7]) * 62'(t_pipe_reg[7]);

    // Argument scaling and its square.
    always_ff @(posedge aclk) begin
        if (ce) begin
            t_pipe_reg[1]  <= {f_in, 16'd0};
            t_pipe_reg[2]  <= t_pipe_reg[1];
            t2_pipe_reg[2] <= tt[60:30];
        end
    end

    // One Horner step per stage.
    for (genvar k = 3; k <= 7; k++) begin : g_horner
        logic [30:0] acc_prev;
        logic [61:0] prod;
        if (k == 3) begin : g_first
            assign acc_prev = SIN_C11;
        end else begin : g_rest
            assign acc_prev = acc_reg[k-1];
        end
        assign prod = 62'(acc_prev) * 62'(t2_pipe_reg[k-1]);
        always_ff @(posedge aclk) begin
            if (ce) begin
                acc_reg[k]    <= HORNER_C[k-3] - prod[60:30];
                t_pipe_reg[k] <= t_pipe_reg[k-1];
            end
        end
        if (k < 7) begin : g_t2
            always_ff @(posedge aclk) begin
                if (ce) begin
                    t2_pipe_reg[k] <= t2_pipe_reg[k-1];
                end
            end
        end
    end

    // Final multiply by the argument.
    always_ff @(posedge aclk) begin
        if (ce) begin
            sin_reg <= fin[60:32];
        end
    end

    assign sin_out = sin_reg;

endmodule

// File: hdl/rsq_vertex.sv
// Corner sequencer and vertex rotation pipeline: four vertices per sprite.
// Depends on rsq_pkg for sprite_t and corner codes.
module rsq_vertex import rsq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         spr_valid,
    output logic         spr_ready,
    input  sprite_t      spr,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    output logic         m_tlast,
    output logic [1:0]   m_tuser
);

    typedef struct packed {
        logic signed [34:0] base_x;
        logic signed [34:0] base_y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        tint;
        corner_t            corner;
    } carry_t;

    localparam int NSTG = 6;

    logic        vld_reg [1:NSTG];
    carry_t      cr_reg  [1:NSTG];
    logic        ce;
    logic        issue;

    logic        exp_valid_reg;
    logic [1:0]  cnt_reg;
    sprite_t     spr_reg;

    logic signed [33:0] x1_reg, y1_reg;
    logic signed [29:0] sn1_reg, cs1_reg;
    logic signed [46:0] xc_h_reg, ys_h_reg, xs_h_reg, yc_h_reg;
    logic signed [47:0] xc_l_reg, ys_l_reg, xs_l_reg, yc_l_reg;
    logic signed [63:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [63:0] sx_reg, sy_reg;
    logic signed [35:0] rx_reg, ry_reg;
    logic [31:0]        vx_reg, vy_reg;
    logic signed [63:0] sx_rnd, sy_rnd;
    logic signed [39:0] px_sum, py_sum;
    carry_t             c_new;

    assign ce        = !vld_reg[NSTG] || m_tready;
    assign issue     = exp_valid_reg && ce;
    assign spr_ready = !exp_valid_reg || (ce && cnt_reg == CORNER_TL);

    // Hold one sprite and step through its corners.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end else if (spr_ready) begin
            exp_valid_reg <= spr_valid;
            cnt_reg       <= 2'd0;
        end else if (issue) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (spr_ready && spr_valid) begin
            spr_reg <= spr;
        end
    end

    // Corner selection.
    always_comb begin
        c_new.base_x = spr_reg.base_x;
        c_new.base_y = spr_reg.base_y;
        c_new.tint   = spr_reg.tint;
        c_new.corner = corner_t'(cnt_reg);
        case (corner_t'(cnt_reg))
            CORNER_BL: begin
                c_new.u = spr_reg.u0;
                c_new.v = spr_reg.v1;
            end
            CORNER_BR: begin
                c_new.u = spr_reg.u1;
                c_new.v = spr_reg.v1;
            end
            CORNER_TR: begin
                c_new.u = spr_reg.u1;
                c_new.v = spr_reg.v0;
            end
            default: begin
                c_new.u = spr_reg.u0;
                c_new.v = spr_reg.v0;
            end
        endcase
    end

    // Valid bits and side data travel together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[1] <= issue;
            for (int i = 2; i <= NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cr_reg[1] <= c_new;
            for (int i = 2; i <= NSTG; i++) begin
                cr_reg[i] <= cr_reg[i-1];
            end
        end
    end

    // Stage 1: corner coordinates and rotation terms.
    always_ff @(posedge aclk) begin
        if (ce) begin
            x1_reg  <= (cnt_reg == CORNER_BR || cnt_reg == CORNER_TR) ?
                       spr_reg.x_right : spr_reg.x_left;
            y1_reg  <= (cnt_reg == CORNER_TR || cnt_reg == CORNER_TL) ?
                       spr_reg.y_top : spr_reg.y_bot;
            sn1_reg <= spr_reg.sn;
            cs1_reg <= spr_reg.cs;
        end
    end

    // Stage 2: partial products, each coordinate split into high and low halves.
    logic signed [16:0] xh, yh;
    logic signed [17:0] xl, yl;
    assign xh = x1_reg[33:17];
    assign yh = y1_reg[33:17];
    assign xl = signed'({1'b0, x1_reg[16:0]});
    assign yl = signed'({1'b0, y1_reg[16:0]});

    always_ff @(posedge aclk) begin
        if (ce) begin
            xc_h_reg <= 47'(xh) * 47'(cs1_reg);
            ys_h_reg <= 47'(yh) * 47'(sn1_reg);
            xs_h_reg <= 47'(xh) * 47'(sn1_reg);
            yc_h_reg <= 47'(yh) * 47'(cs1_reg);
            xc_l_reg <= 48'(xl) * 48'(cs1_reg);
            ys_l_reg <= 48'(yl) * 48'(sn1_reg);
            xs_l_reg <= 48'(xl) * 48'(sn1_reg);
            yc_l_reg <= 48'(yl) * 48'(cs1_reg);
        end
    end

    // Stage 3: full products.
    always_ff @(posedge aclk) begin
        if (ce) begin
            xc_reg <= (64'(xc_h_reg) <<< 17) + 64'(xc_l_reg);
            ys_reg <= (64'(ys_h_reg) <<< 17) + 64'(ys_l_reg);
            xs_reg <= (64'(xs_h_reg) <<< 17) + 64'(xs_l_reg);
            yc_reg <= (64'(yc_h_reg) <<< 17) + 64'(yc_l_reg);
        end
    end

    // Stage 4: rotated sums.
    always_ff @(posedge aclk) begin
        if (ce) begin
            sx_reg <= xc_reg - ys_reg;
            sy_reg <= xs_reg + yc_reg;
        end
    end

    // Stage 5: round Q.28 to Q16.16, halves upward.
    assign sx_rnd = sx_reg + 64'sd134217728;
    assign sy_rnd = sy_reg + 64'sd134217728;

    always_ff @(posedge aclk) begin
        if (ce) begin
            rx_reg <= sx_rnd[63:28];
            ry_reg <= sy_rnd[63:28];
        end
    end

    // Stage 6: translate and saturate into the output register.
    assign px_sum = 40'(cr_reg[5].base_x) + 40'(rx_reg);
    assign py_sum = 40'(cr_reg[5].base_y) + 40'(ry_reg);

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            vx_reg <= sat32(px_sum);
            vy_reg <= sat32(py_sum);
        end
    end

    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = {cr_reg[NSTG].tint, cr_reg[NSTG].v, cr_reg[NSTG].u, vy_reg, vx_reg};
    assign m_tuser  = cr_reg[NSTG].corner;
    assign m_tlast  = (cr_reg[NSTG].corner == CORNER_TL);

endmodule

// File: hdl/rotated_sprite_quad_expand.sv
// Top level of the rotated sprite quad expander: input register, sine and origin
// pipeline, quadrant fold. Depends on rsq_pkg, rsq_sine and rsq_vertex.
//
//  channel | dir | ports                        | content
//  sprite  | in  | s_tvalid s_tready s_tdata    | one sprite, 272-bit tdata
//  vertex  | out | m_tvalid m_tready m_tdata    | one vertex, corner in tuser,
//          |     | m_tlast m_tuser              | tlast on the top-left corner
//
// Full throughput is set by the vertex pipeline, which takes one corner per cycle
// unless m_tready stalls it, and takes the next sprite as it issues the last
// corner of the current one. A sprite passes the input register, the 8-stage
// sine, the corner sequencer and the 6 vertex stages before its first vertex.
// Reset clears only valid bits and the corner counter.
// A stall on m_tready freezes the vertex pipeline; the sprite pipeline keeps
// filling its bubbles and stops only when its last stage waits.
module rotated_sprite_quad_expand import rsq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0] pos_y[63:32] size_w[94:64] size_h[125:95] pivot_fx[141:126]
    // pivot_fy[157:142] angle[173:158] tex_u0[189:174] tex_u1[205:190]
    // tex_v0[221:206] tex_v1[237:222] tint[269:238], zero above
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vert_x[31:0] vert_y[63:32] vert_u[79:64] vert_v[95:80] vert_tint[127:96]
    output logic [127:0] m_tdata,
    output logic         m_tlast,
    // corner[1:0]
    output logic [1:0]   m_tuser
);

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [30:0]        w;
        logic [30:0]        h;
        logic [31:0]        ox;
        logic [31:0]        oy;
        logic [1:0]         quad;
        logic [15:0]        u0;
        logic [15:0]        u1;
        logic [15:0]        v0;
        logic [15:0]        v1;
        logic [31:0]        tint;
    } side_t;

    logic          sv_reg   [0:SINE_LAT];
    logic [271:0]  in_reg;
    side_t         side_reg [1:SINE_LAT];
    logic          ce_f;
    logic          spr_ready;
    logic [14:0]   f_s, f_c;
    logic [28:0]   sin_s, sin_c;
    logic [46:0]   ox_prod, oy_prod;
    sprite_t       spr;
    side_t         sd;

    assign ce_f     = !sv_reg[SINE_LAT] || spr_ready;
    assign s_tready = ce_f;

    // Valid bits of the sprite pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= SINE_LAT; i++) begin
                sv_reg[i] <= 1'b0;
            end
        end else if (ce_f) begin
            sv_reg[0] <= s_tvalid;
            for (int i = 1; i <= SINE_LAT; i++) begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    // Input register, origin products and the side data delay line.
    assign ox_prod = 47'(in_reg[94:64]) * 47'(in_reg[141:126]);
    assign oy_prod = 47'(in_reg[125:95]) * 47'(in_reg[157:142]);

    always_ff @(posedge aclk) begin
        if (ce_f) begin
            in_reg            <= s_tdata;
            side_reg[1].px    <= in_reg[31:0];
            side_reg[1].py    <= in_reg[63:32];
            side_reg[1].w     <= in_reg[94:64];
            side_reg[1].h     <= in_reg[125:95];
            side_reg[1].ox    <= ox_prod[46:15];
            side_reg[1].oy    <= oy_prod[46:15];
            side_reg[1].quad  <= in_reg[173:172];
            side_reg[1].u0    <= in_reg[189:174];
            side_reg[1].u1    <= in_reg[205:190];
            side_reg[1].v0    <= in_reg[221:206];
            side_reg[1].v1    <= in_reg[237:222];
            side_reg[1].tint  <= in_reg[269:238];
            for (int i = 2; i <= SINE_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Sine of the fraction and of its complement.
    assign f_s = {1'b0, in_reg[171:158]};
    assign f_c = QUARTER_TURN - f_s;

    rsq_sine u_sine_s (.aclk(aclk), .ce(ce_f), .f_in(f_s), .sin_out(sin_s));
    rsq_sine u_sine_c (.aclk(aclk), .ce(ce_f), .f_in(f_c), .sin_out(sin_c));

    // Quadrant fold and corner offsets.
    assign sd = side_reg[SINE_LAT];

    always_comb begin
        spr.base_x  = 35'(sd.px) + signed'({3'b0, sd.ox});
        spr.base_y  = 35'(sd.py) + signed'({3'b0, sd.oy});
        spr.x_left  = -signed'({2'b0, sd.ox});
        spr.x_right = signed'({3'b0, sd.w}) - signed'({2'b0, sd.ox});
        spr.y_bot   = -signed'({2'b0, sd.oy});
        spr.y_top   = signed'({3'b0, sd.h}) - signed'({2'b0, sd.oy});
        spr.u0      = sd.u0;
        spr.u1      = sd.u1;
        spr.v0      = sd.v0;
        spr.v1      = sd.v1;
        spr.tint    = sd.tint;
        case (sd.quad)
            2'd0: begin
                spr.sn = signed'({1'b0, sin_s});
                spr.cs = signed'({1'b0, sin_c});
            end
            2'd1: begin
                spr.sn = signed'({1'b0, sin_c});
                spr.cs = -signed'({1'b0, sin_s});
            end
            2'd2: begin
                spr.sn = -signed'({1'b0, sin_s});
                spr.cs = -signed'({1'b0, sin_c});
            end
            default: begin
                spr.sn = -signed'({1'b0, sin_c});
                spr.cs = signed'({1'b0, sin_s});
            end
        endcase
    end

    rsq_vertex u_vertex (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .spr_valid (sv_reg[SINE_LAT]),
        .spr_ready (spr_ready),
        .spr       (spr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // Quarter-wave values never exceed one in Q1.28.
    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg[SINE_LAT] |-> (sin_s <= 29'd268435456 && sin_c <= 29'd268435456))
        else $error("sine out of range");

    // A waiting sprite keeps its rotation terms.
    a_spr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg[SINE_LAT] && !spr_ready |=> sv_reg[SINE_LAT] && $stable(sin_s)
            && $stable(sin_c))
        else $error("waiting sprite changed");

    // Input is taken only when the last stage can move, and is never lost.
    a_in_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> sv_reg[0])
        else $error("accepted sprite lost");
`endif

endmodule

// File: sim/rotated_sprite_quad_expand_tb.sv
// Self-checking testbench for the rotated sprite quad expander: drives sprite
// requests and checks every vertex against a bit-exact predictor. Depends on rsq_pkg.
module rotated_sprite_quad_expand_tb;
    import rsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One vertex as it appears on the output channel.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] tint;
        corner_t     crn;
        logic        lst;
    } vertex_t;

    // One sprite request; the flag marks rows with typed-in vertex positions,
    // which then hold for all four corners.
    typedef struct {
        logic [31:0] px, py;
        logic [30:0] w, h;
        logic [15:0] fx, fy, ang, u0, u1, v0, v1;
        logic [31:0] tint;
        bit          has_exp;
        logic [31:0] exp_x, exp_y;
    } sprite_req_t;

    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM   = 210;
    localparam int WATCHDOG   = 2000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [271:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;

    vertex_t pending_vertices[$];
    int      mismatches = 0;
    int      vertices_seen = 0;
    int      sprites_sent = 0;
    int      idle_cycles = 0;
    bit      quiet_phase = 1'b0;
    bit      hold_off = 1'b0;
    bit      stim_done = 1'b0;

    always #5 aclk = ~aclk;

    rotated_sprite_quad_expand u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // Quarter-wave sine, Q1.28, odd polynomial in Horner form.
    function automatic longint quarter_wave(input int unsigned f);
        logic [63:0] t, t2, acc;
        t = 64'(f) << 16;
        t2 = (t * t) >> 30;
        acc = 64'(SIN_C11);
        for (int i = 0; i < 5; i++)
            acc = 64'(HORNER_C[i]) - ((acc * t2) >> 30);
        return longint'((acc * t) >> 32);
    endfunction

    // Round a Q.28 sum to Q16.16, halves toward plus infinity.
    function automatic longint to_q16(input longint p);
        return (p + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expand one sprite into its four expected vertices.
    task automatic predict_quad(input sprite_req_t r);
        longint px, py, w, h, ox, oy, s, c, sn, cs, cx, cy;
        vertex_t vx;
        int unsigned f;
        px = longint'(signed'(r.px));
        py = longint'(signed'(r.py));
        w = longint'(r.w);
        h = longint'(r.h);
        ox = (w * longint'(r.fx)) >>> 15;
        oy = (h * longint'(r.fy)) >>> 15;
        f = r.ang[13:0];
        s = quarter_wave(f);
        c = quarter_wave(16384 - f);
        case (r.ang[15:14])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
        for (int k = 0; k < 4; k++) begin
            cx = (k == 1 || k == 2) ? w - ox : -ox;
            cy = (k >= 2) ? h - oy : -oy;
            vx.x = clamp32(px + ox + to_q16(cx * cs - cy * sn));
            vx.y = clamp32(py + oy + to_q16(cx * sn + cy * cs));
            // Rows with a typed-in position check against that value instead.
            if (r.has_exp) begin
                vx.x = r.exp_x;
                vx.y = r.exp_y;
            end
            vx.u = (k == 1 || k == 2) ? r.u1 : r.u0;
            vx.v = (k >= 2) ? r.v0 : r.v1;
            vx.tint = r.tint;
            vx.crn = corner_t'(k);
            vx.lst = (k == 3);
            pending_vertices.push_back(vx);
        end
    endtask

    function automatic sprite_req_t random_sprite();
        sprite_req_t r;
        r.px = $urandom(); r.py = $urandom();
        // Mostly modest sizes and positions, sometimes full range for saturation.
        if ($urandom_range(0, 3) != 0) begin
            r.px = 32'($signed(r.px) >>> $urandom_range(0, 12));
            r.py = 32'($signed(r.py) >>> $urandom_range(0, 12));
            r.w = 31'($urandom() >> $urandom_range(8, 20));
            r.h = 31'($urandom() >> $urandom_range(8, 20));
        end else begin
            r.w = 31'($urandom()); r.h = 31'($urandom());
        end
        r.fx = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
        r.fy = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
        r.ang = 16'($urandom());
        r.u0 = 16'($urandom_range(0, 32768)); r.u1 = 16'($urandom());
        r.v0 = 16'($urandom_range(0, 32768)); r.v1 = 16'($urandom());
        r.tint = $urandom();
        r.has_exp = 1'b0;
        r.exp_x = '0;
        r.exp_y = '0;
        return r;
    endfunction

    // Directed table: extremes, quadrant boundaries, pivots and saturation.
    function automatic sprite_req_t directed_row(input int i);
        sprite_req_t r;
        r = '{px: 0, py: 0, w: 31'h10000, h: 31'h10000, fx: 0, fy: 0, ang: 0,
              u0: 0, u1: 16'h8000, v0: 0, v1: 16'h8000, tint: 32'hFF00_80FF,
              has_exp: 1'b0, exp_x: 0, exp_y: 0};
        case (i)
            1: r.ang = 16'h4000;
            2: r.ang = 16'h8000;
            3: r.ang = 16'hC000;
            4: begin r.ang = 16'hFFFF; r.fx = 16'h4000; r.fy = 16'h4000; end
            5: begin r.fx = 16'hFFFF; r.fy = 16'hFFFF; r.ang = 16'h2000; end
            // Top corner of the range: every vertex saturates high.
            6: begin r.px = 32'h7FFF_FFFF; r.py = 32'h7FFF_FFFF;
                     r.has_exp = 1'b1; r.exp_x = 32'h7FFF_FFFF;
                     r.exp_y = 32'h7FFF_FFFF; end
            // Bottom corner, turned half way: every vertex saturates low.
            7: begin r.px = 32'h8000_0000; r.py = 32'h8000_0000; r.ang = 16'h8000;
                     r.has_exp = 1'b1; r.exp_x = 32'h8000_0000;
                     r.exp_y = 32'h8000_0000; end
            8: begin r.w = 31'h7FFF_FFFF; r.h = 31'h7FFF_FFFF; r.fx = 16'h8000;
                     r.fy = 16'h8000; r.ang = 16'h1234; end
            // Zero size: all four corners sit on the position.
            9: begin r.w = 0; r.h = 0; r.px = 32'h1234_5678;
                     r.has_exp = 1'b1; r.exp_x = 32'h1234_5678; r.exp_y = 32'h0; end
            10: begin r.u0 = 16'hFFFF; r.u1 = 16'hFFFF; r.v0 = 16'hFFFF;
                      r.v1 = 16'hFFFF; r.tint = 32'hFFFF_FFFF; end
            11: begin r.tint = 0; r.u1 = 0; r.v1 = 0; r.ang = 16'h3FFF; end
            12: begin r.px = 32'h7FFF_0000; r.w = 31'h7FFF_FFFF; r.ang = 16'h0001; end
            13: begin r.py = 32'h8000_0000; r.h = 31'h7FFF_FFFF; r.fy = 16'hFFFF; end
            default: ;
        endcase
        return r;
    endfunction

    // Send one sprite request, idling at random first outside the quiet phase.
    task automatic send_sprite(input sprite_req_t r);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata <= {2'b0, r.tint, r.v1, r.v0, r.u1, r.u0, r.ang, r.fy, r.fx,
                    r.h, r.w, r.py, r.px};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_quad(r);
        sprites_sent++;
    endtask

    // Stimulus process.
    initial begin
        sprite_req_t r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_sprite(directed_row(i));
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 60) hold_off = 1'b1;
            if (i == N_RANDOM - 40) quiet_phase = 1'b1;
            r = random_sprite();
            send_sprite(r);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls plus one long hold-off to back up the pipeline.
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (80) @(posedge aclk);
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Vertex checker and watchdog.
    always @(posedge aclk) begin
        vertex_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = '{x: m_tdata[31:0], y: m_tdata[63:32], u: m_tdata[79:64],
                        v: m_tdata[95:80], tint: m_tdata[127:96],
                        crn: corner_t'(m_tuser), lst: m_tlast};
                vertices_seen++;
                if (pending_vertices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected vertex %p", got);
                end else begin
                    want = pending_vertices.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("vertex mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog: no activity, %0d vertices pending",
                         pending_vertices.size());
                $display("rotated_sprite_quad_expand_tb: errors");
                $finish;
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        wait (pending_vertices.size() == 0);
        repeat (40) @(posedge aclk);
        $display("Sent %0d sprites (directed extremes and random), checked %0d vertices.",
                 sprites_sent, vertices_seen);
        if (mismatches == 0 && pending_vertices.size() == 0) begin
            $display("rotated_sprite_quad_expand_tb: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rotated_sprite_quad_expand_tb: errors");
        end
        $finish;
    end
endmodule

// File: rotated_sprite_quad_expand.f
hdl/rsq_pkg.sv
hdl/rsq_sine.sv
hdl/rsq_vertex.sv
hdl/rotated_sprite_quad_expand.sv
sim/rotated_sprite_quad_expand_tb.sv
